// ----- rtl/lsf_pkg.sv -----
// Line substring filter package: transaction payload types, register
// indexes and the byte helpers used by the window cells and the top level.
// Depends on nothing.
package lsf_pkg;

  // Pattern storage held by the configuration registers
  localparam int REG_BYTES = 16;
  localparam int LEN_W     = 5;
  // Cell arithmetic width, covers window positions up to 127
  localparam int POS_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_HEAD   = 3'd0,
    REG_PATTERN_TAIL   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_IGNORE_CASE    = 3'd3,
    REG_INVERT_MATCH   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_char;
    logic       line_end;
  } lsf_in_t;

  typedef struct packed {
    logic line_kept;
    logic pattern_found;
  } lsf_out_t;

  // Fold ASCII upper case to lower case when ignore-case is on
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Pick one pattern byte out of the two 64-bit registers
  function automatic logic [7:0] pattern_byte(input logic [CFG_W-1:0] head,
                                              input logic [CFG_W-1:0] tail,
                                              input logic [3:0]       idx);
    logic [CFG_W-1:0] sel;
    sel = idx[3] ? tail : head;
    return sel[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

// ----- rtl/lsf_cell.sv -----
// One window cell: holds an earlier byte of the line and compares it with
// its pattern byte. Depends on lsf_pkg.
module lsf_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic       valid_i,
  input  logic       active_i,
  input  logic       ignore_case_i,
  input  logic [7:0] pat_i,
  output logic [7:0] byte_o,
  output logic       valid_o,
  output logic       hit_o
);

  logic [7:0] byte_q, byte_d;
  logic       valid_q, valid_d;

  // Advance from the neighbor on each byte, drop the line at its end
  always_comb begin
    byte_d  = byte_q;
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (shift_i) begin
      byte_d  = byte_i;
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // A cell outside the pattern never blocks a match
  assign hit_o = !active_i ||
                 (valid_q && (lsf_pkg::fold_byte(byte_q, ignore_case_i) ==
                              lsf_pkg::fold_byte(pat_i, ignore_case_i)));

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

// ----- rtl/lsf_out_buf.sv -----
// Two-entry result buffer (output register plus skid entry) between the
// match logic and the result channel. Depends on lsf_pkg.
module lsf_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lsf_pkg::lsf_out_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lsf_pkg::lsf_out_t out_data_o
);

  lsf_pkg::lsf_out_t out_q, out_d, skid_q, skid_d;
  logic              out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic              take;

  assign take = out_valid_q && !out_stall_i;

  // Refill the output from the skid entry first, park new results when held
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    priority if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = push_data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (!out_valid_q) begin
      if (push_i) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end
    end else begin
      if (push_i) begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/line_substring_filter_unit.sv -----
// Line substring filter: takes one text byte per clock while not stalled and, on the byte
// marked as the line's last, gives one verdict (line kept, pattern found)
// for a fixed pattern of up to 16 bytes. The byte enters a row of
// PATTERN_MAX-1 window cells that hold the previous bytes of the line; every
// cell compares its byte with its pattern byte in the same cycle. Results go
// through an output register and a skid entry, which takes a verdict when
// the output is held; input stalls only while both hold unread verdicts.
// Registers may be written between bytes and apply from the next byte.
module line_substring_filter_unit #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lsf_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lsf_pkg::lsf_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lsf_pkg::lsf_out_t                out_data_o
);

  localparam int WinDepth = PATTERN_MAX - 1;
  localparam int WinSlots = (WinDepth > 0) ? WinDepth : 1;
  localparam logic [lsf_pkg::LEN_W-1:0] LenCap =
    lsf_pkg::LEN_W'((PATTERN_MAX < lsf_pkg::REG_BYTES) ? PATTERN_MAX : lsf_pkg::REG_BYTES);

  // Configuration registers
  logic [lsf_pkg::CFG_W-1:0] head_q, tail_q;
  logic [lsf_pkg::LEN_W-1:0] plen_q;
  logic                      ic_q, inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      plen_q <= '0;
      ic_q   <= 1'b0;
      inv_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsf_pkg::REG_PATTERN_HEAD:   head_q <= cfg_wdata_i;
        lsf_pkg::REG_PATTERN_TAIL:   tail_q <= cfg_wdata_i;
        lsf_pkg::REG_PATTERN_LENGTH: plen_q <= cfg_wdata_i[lsf_pkg::LEN_W-1:0];
        lsf_pkg::REG_IGNORE_CASE:    ic_q   <= cfg_wdata_i[0];
        lsf_pkg::REG_INVERT_MATCH:   inv_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic                      in_acc;
  logic                      shift, clear;
  logic [lsf_pkg::LEN_W-1:0] len_eff;
  logic [3:0]                last_idx;
  logic                      cur_hit, match;
  logic                      found_q, found_d;
  logic [WinSlots-1:0]       hits;
  logic [WinSlots-1:0]       win_valid;
  logic [7:0]                win_byte [WinSlots];
  lsf_pkg::lsf_out_t         result;
  logic                      buf_full;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign shift      = in_acc && !in_data_i.line_end;
  assign clear      = in_acc && in_data_i.line_end;
  assign in_stall_o = buf_full;

  // Clamp the pattern length to what registers and window can hold
  assign len_eff  = (plen_q > LenCap) ? LenCap : plen_q;
  assign last_idx = 4'(len_eff - lsf_pkg::LEN_W'(1));

  // Compare the incoming byte with the last pattern byte
  assign cur_hit = (len_eff != '0) &&
                   (lsf_pkg::fold_byte(in_data_i.text_char, ic_q) ==
                    lsf_pkg::fold_byte(lsf_pkg::pattern_byte(head_q, tail_q, last_idx), ic_q));

  // Window cells: cell c holds the byte c+1 positions back
  generate
    if (WinDepth > 0) begin : g_win
      for (genvar c = 0; c < WinDepth; c++) begin : g_cell
        logic [lsf_pkg::POS_W-1:0] diff;
        logic                      active;
        logic [7:0]                nb_byte;
        logic                      nb_valid;

        assign diff   = {{(lsf_pkg::POS_W-lsf_pkg::LEN_W){1'b0}}, len_eff} -
                        lsf_pkg::POS_W'(c + 2);
        assign active = {{(lsf_pkg::POS_W-lsf_pkg::LEN_W){1'b0}}, len_eff} >
                        lsf_pkg::POS_W'(c + 1);

        if (c == 0) begin : g_head
          assign nb_byte  = in_data_i.text_char;
          assign nb_valid = 1'b1;
        end else begin : g_body
          assign nb_byte  = win_byte[c-1];
          assign nb_valid = win_valid[c-1];
        end

        lsf_cell u_cell (
          .clk_i         (clk_i),
          .rst_ni        (rst_ni),
          .shift_i       (shift),
          .clear_i       (clear),
          .byte_i        (nb_byte),
          .valid_i       (nb_valid),
          .active_i      (active),
          .ignore_case_i (ic_q),
          .pat_i         (lsf_pkg::pattern_byte(head_q, tail_q, diff[3:0])),
          .byte_o        (win_byte[c]),
          .valid_o       (win_valid[c]),
          .hit_o         (hits[c])
        );
      end
    end else begin : g_nowin
      assign hits        = '1;
      assign win_valid   = '0;
      assign win_byte[0] = 8'h00;
    end
  endgenerate

  assign match = cur_hit && (&hits);

  // Hold the found flag across the line, drop it at the line end
  always_comb begin
    found_d = found_q;
    if (clear) begin
      found_d = 1'b0;
    end else if (shift) begin
      found_d = found_q || match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  assign result.pattern_found = found_q || match;
  assign result.line_kept     = (found_q || match) ^ inv_q;

  lsf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (clear),
    .push_data_i (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The skid entry is only used behind a held output transaction
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid entry full while output register empty");

  // A line end clears the found flag and the window
  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.line_end) |=> (!found_q && (win_valid == '0)))
    else $error("line state not cleared after line end");

  // Valid window bytes form a contiguous run from the newest cell
  a_window_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((win_valid >> 1) & ~win_valid) == '0)
    else $error("gap in window valid bits");

  // After a line end the result channel holds a valid transaction next cycle
  a_verdict_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.line_end) |=> out_valid_o)
    else $error("line end produced no verdict");

endmodule
